FILE: hdl/kdlp_pkg.sv
// Package for the key debouncer with long-press detection.
// Holds the key count, the live-key bits, the command codes and the config indexes.
// No dependencies.
`default_nettype none

package kdlp_pkg;

    // Number of keys. Only the low NUM_KEYS bits of the 8-bit fields are keys.
    localparam int NUM_KEYS = 8;

    localparam int KEY_W  = 8;
    localparam int CMD_W  = 2;
    localparam int CFG_IW = 4;

    localparam logic [KEY_W-1:0] LIVE_KEYS =
        (NUM_KEYS >= KEY_W) ? {KEY_W{1'b1}}
                            : KEY_W'((1 << NUM_KEYS) - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 2'd0,
        CMD_READ_DOWN  = 2'd1,
        CMD_READ_SHORT = 2'd2,
        CMD_READ_LONG  = 2'd3
    } t_cmd;

    localparam logic [CFG_IW-1:0] CFG_LONG_KEY_SELECT  = 4'd0;
    localparam logic [CFG_IW-1:0] CFG_LONG_DELAY_TICKS = 4'd1;

    localparam logic [KEY_W-1:0] RST_LONG_KEY_SELECT  = 8'd255;
    localparam logic [KEY_W-1:0] RST_LONG_DELAY_TICKS = 8'd100;

endpackage

`default_nettype wire

FILE: hdl/key_debounce_long_press_top.sv
// An accepted input word's result word is registered in the output register, valid in the next cycle.
// Throughput: one word per cycle; the state update is a single pass of bitwise logic
// and one 8-bit decrement. A new word is taken in the cycle the previous result leaves;
// a stalled result holds the input off.
// Reset (i_rst_n, synchronous, active low): counters, debounced state, flags and the
// long-press counter clear; long_key_select = 255, long_delay_ticks = 100. Needs kdlp_pkg.
`default_nettype none

module key_debounce_long_press_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] raw_pins, [15:8] key_select
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] keys
    // config write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [kdlp_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    logic [7:0] r_long_key_select, r_long_delay_ticks;
    logic [7:0] r_count_low, r_count_high, r_debounced;
    logic [7:0] r_press_flags, r_long_flags, r_long_counter;
    logic [7:0] r_keys;
    logic       r_out_valid;

    logic [7:0] n_count_low, n_count_high, n_debounced;
    logic [7:0] n_press_flags, n_long_flags, n_long_counter;
    logic [7:0] n_keys;

    logic          w_accept;
    logic          w_tick;
    kdlp_pkg::t_cmd w_cmd;
    logic [7:0]    w_pins, w_sel;
    logic [7:0]    w_pressed, w_diff, w_toggle, w_held, w_m, w_lc_base;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign w_cmd  = kdlp_pkg::t_cmd'(s_axis_tuser);
    assign w_pins = s_axis_tdata[7:0];
    assign w_sel  = s_axis_tdata[15:8] & kdlp_pkg::LIVE_KEYS;
    assign w_tick = (w_cmd == kdlp_pkg::CMD_TICK);

    always_comb begin
        n_count_low    = r_count_low;
        n_count_high   = r_count_high;
        n_debounced    = r_debounced;
        n_press_flags  = r_press_flags;
        n_long_flags   = r_long_flags;
        n_long_counter = r_long_counter;

        // vertical two-bit counters, one per key
        w_pressed = ~w_pins & kdlp_pkg::LIVE_KEYS;
        w_diff    = r_debounced ^ w_pressed;
        w_toggle  = '0;
        w_held    = '0;
        w_lc_base = r_long_counter;
        w_m       = '0;

        case (w_cmd)
            kdlp_pkg::CMD_TICK: begin
                n_count_low   = ~(r_count_low & w_diff);
                n_count_high  = n_count_low ^ (r_count_high & w_diff);
                w_toggle      = w_diff & n_count_low & n_count_high;
                n_debounced   = r_debounced ^ w_toggle;
                n_press_flags = r_press_flags | (n_debounced & w_toggle);
                // long-press counter reloads while nothing selected is held
                w_held        = n_debounced & r_long_key_select;
                w_lc_base     = (w_held == '0) ? r_long_delay_ticks : r_long_counter;
                n_long_counter = w_lc_base - 8'd1;
                if (n_long_counter == '0) begin
                    n_long_flags = r_long_flags | w_held;
                end
                w_m = n_debounced;
            end
            kdlp_pkg::CMD_READ_DOWN: begin
                w_m = w_sel & r_press_flags;
            end
            kdlp_pkg::CMD_READ_SHORT: begin
                // released keys with a pending press: report and clear
                w_m           = w_sel & r_press_flags & ~r_debounced;
                n_press_flags = r_press_flags ^ w_m;
                n_long_flags  = r_long_flags & ~w_m;
            end
            kdlp_pkg::CMD_READ_LONG: begin
                w_m = w_sel & r_long_flags;
                if ((r_press_flags & w_m) == '0) begin
                    w_m = '0;
                end
            end
            default: begin
                w_m = '0;
            end
        endcase
        n_keys = w_m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_key_select  <= kdlp_pkg::RST_LONG_KEY_SELECT;
            r_long_delay_ticks <= kdlp_pkg::RST_LONG_DELAY_TICKS;
            r_count_low        <= '0;
            r_count_high       <= '0;
            r_debounced        <= '0;
            r_press_flags      <= '0;
            r_long_flags       <= '0;
            r_long_counter     <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == kdlp_pkg::CFG_LONG_KEY_SELECT) begin
                    r_long_key_select <= i_cfg_data;
                end else if (i_cfg_index == kdlp_pkg::CFG_LONG_DELAY_TICKS) begin
                    r_long_delay_ticks <= i_cfg_data;
                end
            end
            if (w_accept) begin
                r_count_low    <= n_count_low;
                r_count_high   <= n_count_high;
                r_debounced    <= n_debounced;
                r_press_flags  <= n_press_flags;
                r_long_flags   <= n_long_flags;
                r_long_counter <= n_long_counter;
                r_out_valid    <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    // result word: payload register, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_keys <= n_keys;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_keys;

    // only real keys can ever be debounced or flagged
    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_debounced | r_press_flags | r_long_flags) & ~kdlp_pkg::LIVE_KEYS) == '0)
        else $error("state bit set outside the live keys");

    // debounced state moves only on an accepted tick
    a_deb_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_debounced != $past(r_debounced))
        |-> $past(w_accept && w_tick))
        else $error("debounced state changed without a tick");

    // new long flags appear only on a tick
    a_long_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && ((r_long_flags & ~$past(r_long_flags)) != '0)
        |-> $past(w_accept && w_tick))
        else $error("long flag set without a tick");

    // every accepted word leaves a result in the output register
    a_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted word produced no result");

endmodule

`default_nettype wire
